FILE: sv/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
// Request, result, command and status structs and the status and kind codes.
// No dependencies.
package bra_pkg;

    localparam int DEF_TOTAL_BLOCKS = 1024;
    localparam int DEF_WORD_BITS    = 32;

    localparam int KIND_W   = 1;
    localparam int LEN_W    = 11;
    localparam int FIRST_W  = 10;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LEN_W-1:0]   run_length;
        logic [FIRST_W-1:0] first_block;
    } bra_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_index;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } bra_rsp_t;

    typedef struct packed {
        logic                clear_step;
        logic                load;
        logic                scan_init;
        logic                scan_step;
        logic                found;
        logic                upd_init;
        logic                upd_step;
        logic                commit;
        logic                reply;
        logic [STATUS_W-1:0] code;
    } bra_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic len_zero;
        logic len_long;
        logic free_empty;
        logic hit;
        logic scan_last;
        logic upd_last;
    } bra_sts_t;

endpackage

FILE: sv/bra_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bra_dpath.sv
// Datapath of the bitmap run allocator: map RAM, word scan, range update, counts.
// Depends on bra_pkg and bra_ram; driven by bra_ctrl through bra_cmd_t.
module bra_dpath import bra_pkg::*; #(
    parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS,
    parameter int WORD_BITS    = DEF_WORD_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  bra_req_t request,
    input  bra_cmd_t cmd,
    output bra_sts_t sts,
    output logic     done,
    output bra_rsp_t result
);

    localparam int MAP_WORDS = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(TOTAL_BLOCKS + 1);
    localparam int IDX_W     = $clog2(TOTAL_BLOCKS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SUM_W     = $clog2(TOTAL_BLOCKS + 2 * WORD_BITS);
    localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    logic [KIND_W-1:0]    kind_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [IDX_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic                 zero_reg;
    logic                 long_reg;
    logic                 empty_reg;
    logic [CNT_W-1:0]     run_reg;
    logic [IDX_W-1:0]     end_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic [ADDR_W-1:0]    rd_addr_next;
    logic                 dv_reg;
    logic                 dv_next;
    logic [SUM_W-1:0]     base_reg;
    logic [SUM_W-1:0]     base_next;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     used_next;
    logic                 done_reg;
    bra_rsp_t             result_reg;

    logic [CMP_W-1:0]     req_len;
    logic [CMP_W-1:0]     req_first;
    logic [CMP_W-1:0]     total_c;
    logic [CMP_W-1:0]     room;
    logic [CMP_W-1:0]     free_n;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] used_v;
    logic [WORD_BITS-1:0] hit_v;
    logic [WORD_BITS-1:0] upd_word;
    logic [WORD_BITS-1:0] have_l [0:BIT_W];
    logic [BIT_W-1:0]     pos_l  [0:BIT_W][0:WORD_BITS-1];
    logic [CNT_W-1:0]     run_v  [0:WORD_BITS-1];
    logic [BIT_W-1:0]     hit_idx;
    logic                 hit_any;
    logic [SUM_W-1:0]     word_end;
    logic [CNT_W:0]       used_sum;
    logic [CNT_W-1:0]     add_sat;
    logic [CNT_W-1:0]     sub_sat;

    bra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        req_len   = CMP_W'(request.run_length);
        req_first = CMP_W'(request.first_block);
        total_c   = CMP_W'(TOTAL_BLOCKS);
        room      = (req_first < total_c) ? (total_c - req_first) : '0;
        free_n    = (req_len < room) ? req_len : room;
    end

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            used_v[i]    = ram_rdata[i] | ((base_reg + SUM_W'(i)) >= SUM_W'(TOTAL_BLOCKS));
            have_l[0][i] = used_v[i];
            pos_l[0][i]  = BIT_W'(i);
            upd_word[i]  = ((base_reg + SUM_W'(i)) >= SUM_W'(lo_reg)
                            && (base_reg + SUM_W'(i)) < SUM_W'(hi_reg))
                           ? (kind_reg == KIND_ALLOC) : ram_rdata[i];
        end
        for (int l = 0; l < BIT_W; l++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (i >= (1 << l) && !have_l[l][i])
                begin
                    have_l[l+1][i] = have_l[l][i - (1 << l)];
                    pos_l[l+1][i]  = pos_l[l][i - (1 << l)];
                end
                else
                begin
                    have_l[l+1][i] = have_l[l][i];
                    pos_l[l+1][i]  = pos_l[l][i];
                end
            end
        end
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (used_v[i])
            begin
                run_v[i] = '0;
            end
            else if (!have_l[BIT_W][i])
            begin
                run_v[i] = run_reg + CNT_W'(i + 1);
            end
            else
            begin
                run_v[i] = CNT_W'(i) - CNT_W'(pos_l[BIT_W][i]);
            end
            hit_v[i] = (run_v[i] >= len_reg);
        end
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hit_v[i])
            begin
                hit_idx = BIT_W'(i);
            end
        end
        hit_any  = |hit_v;
        word_end = base_reg + SUM_W'(WORD_BITS);
    end

    always_comb
    begin
        sts.clear_last = (rd_addr_reg == LAST_ADDR);
        sts.is_free    = (kind_reg == KIND_FREE);
        sts.len_zero   = zero_reg;
        sts.len_long   = long_reg;
        sts.free_empty = empty_reg;
        sts.hit        = dv_reg & hit_any;
        sts.scan_last  = dv_reg & (word_end >= SUM_W'(TOTAL_BLOCKS));
        sts.upd_last   = dv_reg & (word_end >= SUM_W'(hi_reg));
    end

    always_comb
    begin
        ram_we    = cmd.clear_step | (cmd.upd_step & dv_reg);
        ram_waddr = cmd.clear_step ? rd_addr_reg : ADDR_W'(base_reg >> BIT_W);
        ram_wdata = cmd.clear_step ? '0 : upd_word;
    end

    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        dv_next      = dv_reg;
        base_next    = base_reg;
        if (cmd.clear_step)
        begin
            rd_addr_next = (rd_addr_reg == LAST_ADDR) ? '0 : rd_addr_reg + 1'b1;
        end
        else if (cmd.scan_init)
        begin
            rd_addr_next = '0;
            dv_next      = 1'b0;
            base_next    = '0;
        end
        else if (cmd.upd_init)
        begin
            rd_addr_next = ADDR_W'(lo_reg >> BIT_W);
            dv_next      = 1'b0;
            base_next    = SUM_W'(lo_reg >> BIT_W) << BIT_W;
        end
        else if (cmd.scan_step || cmd.upd_step)
        begin
            if (rd_addr_reg != LAST_ADDR)
            begin
                rd_addr_next = rd_addr_reg + 1'b1;
            end
            dv_next = 1'b1;
            if (dv_reg)
            begin
                base_next = word_end;
            end
        end
    end

    always_comb
    begin
        used_sum  = {1'b0, used_reg} + {1'b0, len_reg};
        add_sat   = (used_sum > (CNT_W + 1)'(TOTAL_BLOCKS)) ? CNT_W'(TOTAL_BLOCKS)
                                                            : used_sum[CNT_W-1:0];
        sub_sat   = (len_reg >= used_reg) ? '0 : (used_reg - len_reg);
        used_next = used_reg;
        if (cmd.commit)
        begin
            used_next = (kind_reg == KIND_ALLOC) ? add_sat : sub_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            dv_reg      <= 1'b0;
            base_reg    <= '0;
            used_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            dv_reg      <= dv_next;
            base_reg    <= base_next;
            used_reg    <= used_next;
            done_reg    <= cmd.reply;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= request.kind;
            zero_reg  <= (req_len == '0);
            long_reg  <= (req_len > total_c);
            empty_reg <= (free_n == '0);
            len_reg   <= CNT_W'((request.kind == KIND_FREE) ? free_n : req_len);
            lo_reg    <= IDX_W'(request.first_block);
            hi_reg    <= CNT_W'(req_first + free_n);
        end
        if (cmd.found)
        begin
            lo_reg <= IDX_W'(CNT_W'(end_reg) + CNT_W'(1) - len_reg);
            hi_reg <= CNT_W'(end_reg) + CNT_W'(1);
        end
        if (cmd.scan_init)
        begin
            run_reg <= '0;
        end
        else if (cmd.scan_step && dv_reg)
        begin
            run_reg <= run_v[WORD_BITS-1];
            if (hit_any)
            begin
                end_reg <= IDX_W'(base_reg + SUM_W'(hit_idx));
            end
        end
        if (cmd.reply)
        begin
            result_reg.status      <= cmd.code;
            result_reg.start_index <= (cmd.code == ST_DONE && kind_reg == KIND_ALLOC)
                                      ? START_W'(lo_reg) : '0;
            result_reg.used_count  <= COUNT_W'(used_next);
            result_reg.free_count  <= COUNT_W'(CNT_W'(TOTAL_BLOCKS) - used_next);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TOTAL_BLOCKS))
        else $error("used count above map size");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !ram_we)
        else $error("map written during scan");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reply && cmd.code != ST_DONE) |=> (used_reg == $past(used_reg)))
        else $error("failed request changed used count");

    a_alloc_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg == KIND_ALLOC) |-> ((hi_reg - CNT_W'(lo_reg)) == len_reg))
        else $error("allocated range does not match length");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr <= LAST_ADDR))
        else $error("map write outside the map");

endmodule

FILE: sv/bra_ctrl.sv
// Controller of the bitmap run allocator: clear pass, scan, mark and reply sequencing.
// Depends on bra_pkg; drives bra_dpath through bra_cmd_t.
module bra_ctrl import bra_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bra_sts_t sts,
    output bra_cmd_t cmd,
    output logic     busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FOUND  = 3'd4;
    localparam logic [2:0] S_UINIT  = 3'd5;
    localparam logic [2:0] S_UPDATE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_DONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.is_free)
                begin
                    if (sts.free_empty)
                    begin
                        cmd.reply  = 1'b1;
                        cmd.code   = ST_DONE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.upd_init = 1'b1;
                        state_next   = S_UPDATE;
                    end
                end
                else if (sts.len_zero)
                begin
                    cmd.reply  = 1'b1;
                    cmd.code   = ST_ZERO;
                    state_next = S_IDLE;
                end
                else if (sts.len_long)
                begin
                    cmd.reply  = 1'b1;
                    cmd.code   = ST_NOFIT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_FOUND;
                end
                else if (sts.scan_last)
                begin
                    cmd.reply  = 1'b1;
                    cmd.code   = ST_NOFIT;
                    state_next = S_IDLE;
                end
            end
            S_FOUND:
            begin
                cmd.found  = 1'b1;
                state_next = S_UINIT;
            end
            S_UINIT:
            begin
                cmd.upd_init = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.upd_step = 1'b1;
                if (sts.upd_last)
                begin
                    cmd.commit = 1'b1;
                    cmd.reply  = 1'b1;
                    cmd.code   = ST_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: sv/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: first-fit allocation and release of block runs.
// Depends on bra_pkg, bra_ctrl and bra_dpath.
//
// Usage: drive request and raise start; the request is taken at a clock edge with start
// high and busy low. kind selects allocate (search lowest free run of run_length blocks)
// or free (clear run_length blocks from first_block, clipped at the map end).
// Exactly one result follows each request: done is high for one cycle with result valid.
// The receiver cannot stall; the result must be taken in that cycle.
// Steps: a zero or oversized allocate replies straight from the check state. An allocate
// scans one map word per cycle up to the hit, then updates the words covered by the run
// with a read-modify-write of the map RAM; a failed search scans every map word. A free
// updates the words covered by its range, and replies straight from the check state when
// it clears nothing.
// Default map: 32 words of 32 bits.
// busy drops in the cycle done pulses, so the next request can enter then.
// Reset: the map RAM is cleared one word per cycle with busy high; the used count
// resets to zero. WORD_BITS must be a power of two.
module bitmap_run_allocator import bra_pkg::*; #(
    parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS,
    parameter int WORD_BITS    = DEF_WORD_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bra_req_t request,
    output logic     done,
    output bra_rsp_t result
);

    bra_cmd_t cmd;
    bra_sts_t sts;

    bra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bra_dpath #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .WORD_BITS    (WORD_BITS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: bench/tb.sv
// Self-checking bench for bitmap_run_allocator: directed table, then random allocate/free.
// A bitmap predictor in this file computes each expected result that the table does not give.
// Depends on bra_pkg and bitmap_run_allocator.
module tb import bra_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS   = DEF_TOTAL_BLOCKS;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 200;

    typedef struct {
        bra_req_t req;
        bit       typed;
        bra_rsp_t rsp;
    } stim_row_t;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } run_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    bra_req_t request;
    logic     done;
    bra_rsp_t result;

    logic [NUM_BLOCKS-1:0] block_map;
    int unsigned           blocks_used;
    bra_rsp_t              pending_results[$];
    run_t                  live_runs[$];
    stim_row_t             directed_rows[$];
    bit                    gaps_on;
    int                    mismatches;
    int                    cycle_count;

    bitmap_run_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic bra_rsp_t apply_to_map(bra_req_t req);
        bra_rsp_t    rsp;
        int unsigned len;
        int unsigned first;
        int unsigned run;
        int unsigned run_start;
        int unsigned n;
        bit          hit;
        rsp       = '0;
        len       = req.run_length;
        first     = req.first_block;
        run       = 0;
        run_start = 0;
        hit       = 1'b0;
        rsp.status = ST_DONE;
        if (req.kind == KIND_ALLOC)
        begin
            if (len == 0)
                rsp.status = ST_ZERO;
            else
            begin
                if (len <= NUM_BLOCKS)
                begin
                    for (int b = 0; b < NUM_BLOCKS && !hit; b++)
                    begin
                        if (block_map[b])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                run_start = b;
                            run++;
                            if (run == len)
                                hit = 1'b1;
                        end
                    end
                end
                if (!hit)
                    rsp.status = ST_NOFIT;
                else
                begin
                    for (int unsigned b = run_start; b < run_start + len; b++)
                        block_map[b] = 1'b1;
                    blocks_used += len;
                    if (blocks_used > NUM_BLOCKS)
                        blocks_used = NUM_BLOCKS;
                    rsp.start_index = START_W'(run_start);
                end
            end
        end
        else
        begin
            n = 0;
            if (first < NUM_BLOCKS)
                n = (len < NUM_BLOCKS - first) ? len : NUM_BLOCKS - first;
            for (int unsigned b = first; b < first + n; b++)
                block_map[b] = 1'b0;
            blocks_used = (n >= blocks_used) ? 0 : blocks_used - n;
        end
        rsp.used_count = COUNT_W'(blocks_used);
        rsp.free_count = COUNT_W'(NUM_BLOCKS - blocks_used);
        return rsp;
    endfunction

    task automatic send_request(bra_req_t req, bit typed, bra_rsp_t typed_rsp);
        bra_rsp_t predicted;
        while (gaps_on && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_to_map(req);
        if (req.kind == KIND_ALLOC && predicted.status == ST_DONE)
            live_runs.push_back('{predicted.start_index, req.run_length});
        pending_results.push_back(typed ? typed_rsp : predicted);
    endtask

    function automatic void add_row(logic [KIND_W-1:0] kind, int len, int first, bit typed,
                                    logic [STATUS_W-1:0] status, int start_idx, int used);
        stim_row_t row;
        row.req.kind        = kind;
        row.req.run_length  = LEN_W'(len);
        row.req.first_block = FIRST_W'(first);
        row.typed           = typed;
        row.rsp.status      = status;
        row.rsp.start_index = START_W'(start_idx);
        row.rsp.used_count  = COUNT_W'(used);
        row.rsp.free_count  = COUNT_W'(NUM_BLOCKS - used);
        directed_rows.push_back(row);
    endfunction

    always @(posedge clk)
    begin : check_results
        bra_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with no request outstanding, status %0d",
                                          result.status));
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.start_index !== want.start_index)
                    report_mismatch($sformatf("start_index got %0d want %0d",
                                              result.start_index, want.start_index));
                if (result.used_count !== want.used_count)
                    report_mismatch($sformatf("used_count got %0d want %0d",
                                              result.used_count, want.used_count));
                if (result.free_count !== want.free_count)
                    report_mismatch($sformatf("free_count got %0d want %0d",
                                              result.free_count, want.free_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        bra_req_t req;
        bra_rsp_t no_rsp;
        int       pick;
        int       idx;
        mismatches  = 0;
        cycle_count = 0;
        block_map   = '0;
        blocks_used = 0;
        no_rsp      = '0;
        gaps_on     = 1'b1;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;

        add_row(KIND_ALLOC, 0,    0,    1'b1, ST_ZERO,  0,    0);
        add_row(KIND_ALLOC, 2047, 1023, 1'b1, ST_NOFIT, 0,    0);
        add_row(KIND_ALLOC, 1025, 0,    1'b1, ST_NOFIT, 0,    0);
        add_row(KIND_ALLOC, 1,    1023, 1'b1, ST_DONE,  0,    1);
        add_row(KIND_ALLOC, 1,    0,    1'b1, ST_DONE,  1,    2);
        add_row(KIND_ALLOC, 1024, 0,    1'b1, ST_NOFIT, 0,    2);
        add_row(KIND_FREE,  0,    0,    1'b1, ST_DONE,  0,    2);
        add_row(KIND_FREE,  1,    1,    1'b1, ST_DONE,  0,    1);
        add_row(KIND_ALLOC, 2,    512,  1'b0, ST_DONE,  0,    0);
        add_row(KIND_FREE,  2047, 0,    1'b1, ST_DONE,  0,    0);
        add_row(KIND_FREE,  3,    5,    1'b1, ST_DONE,  0,    0);
        add_row(KIND_ALLOC, 1024, 1023, 1'b1, ST_DONE,  0,    1024);
        add_row(KIND_ALLOC, 1,    0,    1'b1, ST_NOFIT, 0,    1024);
        add_row(KIND_FREE,  2047, 1023, 1'b1, ST_DONE,  0,    1023);
        add_row(KIND_ALLOC, 1,    0,    1'b1, ST_DONE,  1023, 1024);
        add_row(KIND_FREE,  40,   1000, 1'b1, ST_DONE,  0,    1000);
        add_row(KIND_ALLOC, 25,   0,    1'b1, ST_NOFIT, 0,    1000);
        add_row(KIND_ALLOC, 24,   0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_FREE,  512,  0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_FREE,  512,  512,  1'b1, ST_DONE,  0,    0);
        add_row(KIND_ALLOC, 31,   0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_ALLOC, 33,   0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_FREE,  5,    10,   1'b0, ST_DONE,  0,    0);
        add_row(KIND_ALLOC, 6,    0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_ALLOC, 5,    0,    1'b0, ST_DONE,  0,    0);
        add_row(KIND_FREE,  10,   900,  1'b0, ST_DONE,  0,    0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gaps_on = !(i >= 800 && i < 1100);
            pick = $urandom_range(99);
            req.first_block = FIRST_W'($urandom);
            if (pick < 45)
            begin
                req.kind = KIND_ALLOC;
                req.run_length = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(1024, 49))
                                                          : LEN_W'($urandom_range(48, 1));
            end
            else if (pick < 80 && live_runs.size() != 0)
            begin
                idx = $urandom_range(live_runs.size() - 1);
                req.kind        = KIND_FREE;
                req.first_block = FIRST_W'(live_runs[idx].first);
                req.run_length  = LEN_W'(live_runs[idx].len);
                live_runs.delete(idx);
            end
            else if (pick < 90)
            begin
                req.kind = KIND_FREE;
                req.run_length = ($urandom_range(3) == 0) ? LEN_W'($urandom)
                                                          : LEN_W'($urandom_range(64));
            end
            else
            begin
                req.kind       = KIND_ALLOC;
                req.run_length = LEN_W'($urandom);
            end
            send_request(req, 1'b0, no_rsp);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: bitmap_run_allocator.f
sv/bra_pkg.sv
sv/bra_ram.sv
sv/bra_dpath.sv
sv/bra_ctrl.sv
sv/bitmap_run_allocator.sv
bench/tb.sv
